// File: hw/rtl/tzc_pkg.sv
// ----------------------------------------------------------------------------
// tzc_pkg: shared types and constants for the zero-contour segment block
// Field layouts, the sorted-edge request passed to the dividers, and the
// fixed-point widths used along the pipeline.
// ----------------------------------------------------------------------------
package tzc_pkg;

  localparam int VAL_W   = 32;                // Q16.16 scalar
  localparam int COORD_W = 24;                // Q4.20 coordinate
  localparam int WFRAC   = 16;                // weight fraction bits
  localparam int QW      = WFRAC + 1;         // weight width, 0..1.0 inclusive
  localparam int NUM_W   = 1 + VAL_W + WFRAC; // scaled dividend with rounding
  localparam int DEN_W   = VAL_W;             // vh - vl never exceeds 2^32 - 1
  localparam int IN_W    = 3 * VAL_W + 9 * COORD_W;
  localparam int OUT_W   = 6 * COORD_W;

  localparam logic [QW-1:0] WONE = QW'(1) << WFRAC;

  typedef logic signed [VAL_W-1:0]   val_t;
  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t z;
    coord_t y;
    coord_t x;
  } vec3_t;

  // First field sits in the highest bits.
  typedef struct packed {
    coord_t c_z;
    coord_t c_y;
    coord_t c_x;
    coord_t b_z;
    coord_t b_y;
    coord_t b_x;
    coord_t a_z;
    coord_t a_y;
    coord_t a_x;
    val_t   value_c;
    val_t   value_b;
    val_t   value_a;
  } in_item_t;

  typedef struct packed {
    coord_t end_z;
    coord_t end_y;
    coord_t end_x;
    coord_t start_z;
    coord_t start_y;
    coord_t start_x;
  } out_item_t;

  // Low and high endpoints of both edges that carry the segment.
  typedef struct packed {
    vec3_t pl0;
    vec3_t ph0;
    vec3_t pl1;
    vec3_t ph1;
  } side_t;

  typedef struct packed {
    logic [DEN_W-1:0] num0;
    logic [DEN_W-1:0] den0;
    logic [DEN_W-1:0] num1;
    logic [DEN_W-1:0] den1;
    side_t            side;
  } sort_out_t;

endpackage

// File: hw/rtl/tzc_sort.sv
// ----------------------------------------------------------------------------
// tzc_sort: vertex ranking and edge selection
// Ranks the three vertices by value with ties broken by vertex order, picks
// the crossed edge pair and forms the divider operands for both edges.
// ----------------------------------------------------------------------------
module tzc_sort (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               item_vld,
  input  tzc_pkg::in_item_t  item,
  output logic               hit_vld_r,
  output tzc_pkg::sort_out_t sort_r
);
  import tzc_pkg::*;

  val_t      val [3];
  vec3_t     pos [3];
  logic      gt_ab, gt_ac, gt_bc;
  logic [1:0] r0, r1, r2;
  val_t      v0, v1, v2;
  logic      lo_hit, up_hit;
  val_t      vl0, vh0, vl1, vh1;
  sort_out_t sort_nxt;
  logic      hit_vld_nxt;

  always_comb begin
    val[0] = item.value_a;
    val[1] = item.value_b;
    val[2] = item.value_c;
    pos[0] = '{z: item.a_z, y: item.a_y, x: item.a_x};
    pos[1] = '{z: item.b_z, y: item.b_y, x: item.b_x};
    pos[2] = '{z: item.c_z, y: item.c_y, x: item.c_x};
  end

  // A vertex ranks after a lower-lettered one only when strictly greater.
  assign gt_ab = item.value_a > item.value_b;
  assign gt_ac = item.value_a > item.value_c;
  assign gt_bc = item.value_b > item.value_c;

  always_comb begin
    case ({gt_ab, gt_ac, gt_bc})
      3'b001:  begin r0 = 2'd0; r1 = 2'd2; r2 = 2'd1; end
      3'b011:  begin r0 = 2'd2; r1 = 2'd0; r2 = 2'd1; end
      3'b100:  begin r0 = 2'd1; r1 = 2'd0; r2 = 2'd2; end
      3'b110:  begin r0 = 2'd1; r1 = 2'd2; r2 = 2'd0; end
      3'b111:  begin r0 = 2'd2; r1 = 2'd1; r2 = 2'd0; end
      default: begin r0 = 2'd0; r1 = 2'd1; r2 = 2'd2; end
    endcase
  end

  assign v0 = val[r0];
  assign v1 = val[r1];
  assign v2 = val[r2];

  assign lo_hit = (v0 < 0 && v1 >= 0) || (v0 <= 0 && v1 > 0);
  assign up_hit = (v1 < 0 && v2 >= 0) || (v1 <= 0 && v2 > 0);

  always_comb begin
    vl0 = v0;
    vh0 = lo_hit ? v1 : v2;
    vl1 = lo_hit ? v0 : v1;
    vh1 = v2;
    sort_nxt.side.pl0 = pos[r0];
    sort_nxt.side.ph0 = lo_hit ? pos[r1] : pos[r2];
    sort_nxt.side.pl1 = lo_hit ? pos[r0] : pos[r1];
    sort_nxt.side.ph1 = pos[r2];
    // The low value is never positive, so its negation fits unsigned.
    sort_nxt.num0 = DEN_W'(-(33'(vl0)));
    sort_nxt.den0 = DEN_W'(33'(vh0) - 33'(vl0));
    sort_nxt.num1 = DEN_W'(-(33'(vl1)));
    sort_nxt.den1 = DEN_W'(33'(vh1) - 33'(vl1));
    hit_vld_nxt   = item_vld && (lo_hit || up_hit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_vld_r <= 1'b0;
    end else if (en) begin
      hit_vld_r <= hit_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sort_r <= sort_nxt;
    end
  end

endmodule

// File: hw/rtl/tzc_div.sv
// ----------------------------------------------------------------------------
// tzc_div: pipelined edge-weight divider
// Restoring division, one quotient bit per stage, giving the rounded weight
// round(num * 2^16 / den) in QW stages.
// ----------------------------------------------------------------------------
module tzc_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [tzc_pkg::DEN_W-1:0] num,
  input  logic [tzc_pkg::DEN_W-1:0] den,
  output logic [tzc_pkg::QW-1:0]    quo
);
  import tzc_pkg::*;

  logic [NUM_W-1:0] rem_r [QW];
  logic [DEN_W-1:0] den_r [QW];
  logic [QW-1:0]    quo_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_st
    logic [NUM_W-1:0] rin;
    logic [NUM_W-1:0] dsh;
    logic [DEN_W-1:0] din;
    logic [QW-1:0]    qin;
    logic             take;

    if (k == 0) begin : g_first
      // Half the divisor is added up front for round-half-up.
      assign rin = {1'b0, num, WFRAC'(0)} + NUM_W'(den[DEN_W-1:1]);
      assign din = den;
      assign qin = '0;
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = den_r[k-1];
      assign qin = quo_r[k-1];
    end

    assign dsh  = NUM_W'(din) << (QW - 1 - k);
    assign take = rin >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= take ? rin - dsh : rin;
        den_r[k] <= din;
        quo_r[k] <= qin | (QW'(take) << (QW - 1 - k));
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

// File: hw/rtl/tzc_blend.sv
// ----------------------------------------------------------------------------
// tzc_blend: one-coordinate interpolation
// Computes pl + (ph - pl) * t in two stages, rounds half up to Q4.20 and
// saturates to the coordinate range.
// ----------------------------------------------------------------------------
module tzc_blend (
  input  logic                   clk,
  input  logic                   en,
  input  logic [tzc_pkg::QW-1:0] t,
  input  tzc_pkg::coord_t        pl,
  input  tzc_pkg::coord_t        ph,
  output tzc_pkg::coord_t        res_r
);
  import tzc_pkg::*;

  localparam int DIFF_W = COORD_W + 1;
  localparam int PROD_W = DIFF_W + QW + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam int RES_W  = SUM_W - WFRAC;

  logic signed [DIFF_W-1:0] diff;
  logic signed [PROD_W-1:0] prod_nxt, prod_r;
  coord_t                   pl_r;
  logic signed [SUM_W-1:0]  sum;
  logic signed [RES_W-1:0]  rnd;
  coord_t                   res_nxt;

  assign diff     = DIFF_W'(ph) - DIFF_W'(pl);
  assign prod_nxt = PROD_W'(diff * $signed({1'b0, t}));

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
      pl_r   <= pl;
    end
  end

  always_comb begin
    sum = (SUM_W'(pl_r) <<< WFRAC) + SUM_W'(prod_r) + SUM_W'(WONE >> 1);
    rnd = sum[SUM_W-1:WFRAC];
    if (rnd > RES_W'($signed(coord_t'({1'b0, {(COORD_W-1){1'b1}}})))) begin
      res_nxt = {1'b0, {(COORD_W-1){1'b1}}};
    end else if (rnd < RES_W'($signed(coord_t'({1'b1, {(COORD_W-1){1'b0}}})))) begin
      res_nxt = {1'b1, {(COORD_W-1){1'b0}}};
    end else begin
      res_nxt = rnd[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: hw/rtl/triangle_zero_contour_segment_top.sv
// ----------------------------------------------------------------------------
// triangle_zero_contour_segment_top: zero isoline segment of one triangle
// Ranks the vertex values, finds the crossed edge pair, divides for both
// edge weights and interpolates the two segment endpoints.
//
//   Channel  Dir  Content
//   in_*     in   value_a..c, a..c x/y/z: one triangle per request
//   out_*    out  start_x/y/z, end_x/y/z: one segment, or none per triangle
//
// A triangle is taken in every cycle unless out_tready stalls. Stages: input
// register, ranking stage, 17 divider stages (one weight bit each), and two
// interpolation stages (multiply, then round and saturate).
// Triangles that the zero level does not cross leave a bubble and no request.
// Reset clears only the stage valid bits. A stall on out_tready freezes the
// whole pipeline and drops in_tready in the same cycle.
// ----------------------------------------------------------------------------
module triangle_zero_contour_segment_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // value_a, value_b, value_c, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic [311:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // start_x, start_y, start_z, end_x, end_y, end_z
  output logic [143:0] out_tdata
);
  import tzc_pkg::*;

  logic      en;
  logic      in_vld_r;
  in_item_t  in_item_r;
  logic      sort_vld;
  sort_out_t sort_q;
  logic [QW-1:0] t0, t1;
  side_t     side_r [QW];
  logic [QW+1:0] pipe_vld_r;
  out_item_t res;

  assign en        = !out_tvalid || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r   <= 1'b0;
      pipe_vld_r <= '0;
    end else if (en) begin
      in_vld_r   <= in_tvalid;
      pipe_vld_r <= {pipe_vld_r[QW:0], sort_vld};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_item_r <= in_item_t'(in_tdata);
      side_r[0] <= sort_q.side;
      for (int k = 1; k < QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  tzc_sort u_sort (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .item_vld  (in_vld_r),
    .item      (in_item_r),
    .hit_vld_r (sort_vld),
    .sort_r    (sort_q)
  );

  tzc_div u_div0 (.clk(clk), .en(en), .num(sort_q.num0), .den(sort_q.den0), .quo(t0));
  tzc_div u_div1 (.clk(clk), .en(en), .num(sort_q.num1), .den(sort_q.den1), .quo(t1));

  tzc_blend u_bsx (.clk(clk), .en(en), .t(t0), .pl(side_r[QW-1].pl0.x),
                   .ph(side_r[QW-1].ph0.x), .res_r(res.start_x));
  tzc_blend u_bsy (.clk(clk), .en(en), .t(t0), .pl(side_r[QW-1].pl0.y),
                   .ph(side_r[QW-1].ph0.y), .res_r(res.start_y));
  tzc_blend u_bsz (.clk(clk), .en(en), .t(t0), .pl(side_r[QW-1].pl0.z),
                   .ph(side_r[QW-1].ph0.z), .res_r(res.start_z));
  tzc_blend u_bex (.clk(clk), .en(en), .t(t1), .pl(side_r[QW-1].pl1.x),
                   .ph(side_r[QW-1].ph1.x), .res_r(res.end_x));
  tzc_blend u_bey (.clk(clk), .en(en), .t(t1), .pl(side_r[QW-1].pl1.y),
                   .ph(side_r[QW-1].ph1.y), .res_r(res.end_y));
  tzc_blend u_bez (.clk(clk), .en(en), .t(t1), .pl(side_r[QW-1].pl1.z),
                   .ph(side_r[QW-1].ph1.z), .res_r(res.end_z));

  assign out_tvalid = pipe_vld_r[QW+1];
  assign out_tdata  = res;

  // A selected edge always has distinct end values that bracket zero.
  a_den_nz: assert property (@(posedge clk) disable iff (!rst_n)
    sort_vld |-> (sort_q.den0 != '0 && sort_q.den1 != '0))
    else $error("selected edge has equal end values");

  a_num_le: assert property (@(posedge clk) disable iff (!rst_n)
    sort_vld |-> (sort_q.num0 <= sort_q.den0 && sort_q.num1 <= sort_q.den1))
    else $error("zero level lies outside a selected edge");

  a_wt_max: assert property (@(posedge clk) disable iff (!rst_n)
    pipe_vld_r[QW-1] |-> (t0 <= WONE && t1 <= WONE))
    else $error("edge weight above one");

  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(pipe_vld_r))
    else $error("pipeline moved during a stall");

endmodule

// File: tb/triangle_zero_contour_segment_checker.sv
// ----------------------------------------------------------------------------
// triangle_zero_contour_segment_checker: segment predictor and comparator
// Watches both stream channels, computes the expected isoline segment for
// each accepted triangle and compares every segment that leaves the block.
// ----------------------------------------------------------------------------
module triangle_zero_contour_segment_checker (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [311:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [143:0] out_tdata,
  output int           fail_count,
  output int           pending
);
  import tzc_pkg::*;

  out_item_t segments_due[$];

  assign pending = segments_due.size();

  function automatic longint crossing_weight(longint vl, longint vh);
    longint d;
    longint n;
    d = vh - vl;
    n = -vl;
    if (d == 0) return 0;
    return ((n <<< WFRAC) + (d >>> 1)) / d;
  endfunction

  function automatic coord_t mix_coord(longint pl, longint ph, longint t);
    longint s;
    longint r;
    s = pl * (65536 - t) + ph * t + 32768;
    r = s >>> WFRAC;
    if (r > 8388607) r = 8388607;
    if (r < -8388608) r = -8388608;
    return coord_t'(r);
  endfunction

  function automatic vec3_t edge_crossing(longint vl, longint vh, vec3_t pl, vec3_t ph);
    longint t;
    vec3_t q;
    t = crossing_weight(vl, vh);
    q.x = mix_coord(longint'(pl.x), longint'(ph.x), t);
    q.y = mix_coord(longint'(pl.y), longint'(ph.y), t);
    q.z = mix_coord(longint'(pl.z), longint'(ph.z), t);
    return q;
  endfunction

  // Returns 1 and the segment when the zero level crosses the triangle.
  function automatic bit predict_segment(in_item_t tri_in, output out_item_t seg);
    longint val[3];
    vec3_t pos[3];
    int rank[3];
    int a;
    int b;
    vec3_t s0;
    vec3_t s1;
    longint v0;
    longint v1;
    longint v2;
    val[0] = longint'(tri_in.value_a);
    val[1] = longint'(tri_in.value_b);
    val[2] = longint'(tri_in.value_c);
    pos[0] = '{tri_in.a_z, tri_in.a_y, tri_in.a_x};
    pos[1] = '{tri_in.b_z, tri_in.b_y, tri_in.b_x};
    pos[2] = '{tri_in.c_z, tri_in.c_y, tri_in.c_x};
    rank = '{0, 1, 2};
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2 - i; j++) begin
        a = rank[j];
        b = rank[j+1];
        if (val[a] > val[b] || (val[a] == val[b] && a > b)) begin
          rank[j] = b;
          rank[j+1] = a;
        end
      end
    end
    v0 = val[rank[0]];
    v1 = val[rank[1]];
    v2 = val[rank[2]];
    seg = '0;
    if ((v0 < 0 && v1 >= 0) || (v0 <= 0 && v1 > 0)) begin
      s0 = edge_crossing(v0, v1, pos[rank[0]], pos[rank[1]]);
      s1 = edge_crossing(v0, v2, pos[rank[0]], pos[rank[2]]);
    end else if ((v1 < 0 && v2 >= 0) || (v1 <= 0 && v2 > 0)) begin
      s0 = edge_crossing(v0, v2, pos[rank[0]], pos[rank[2]]);
      s1 = edge_crossing(v1, v2, pos[rank[1]], pos[rank[2]]);
    end else begin
      return 0;
    end
    seg.start_x = s0.x;
    seg.start_y = s0.y;
    seg.start_z = s0.z;
    seg.end_x = s1.x;
    seg.end_y = s1.y;
    seg.end_z = s1.z;
    return 1;
  endfunction

  task automatic report(string what, out_item_t want, out_item_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch %s: expected %h actual %h", what, want, got);
  endtask

  always @(posedge clk) begin
    out_item_t seg;
    out_item_t got;
    out_item_t want;
    if (rst_n && in_tvalid && in_tready) begin
      if (predict_segment(in_item_t'(in_tdata), seg)) segments_due.push_back(seg);
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_item_t'(out_tdata);
      if (segments_due.size() == 0) begin
        report("unexpected segment", '0, got);
      end else begin
        want = segments_due.pop_front();
        if (got.start_x != want.start_x) report("start_x", want, got);
        if (got.start_y != want.start_y) report("start_y", want, got);
        if (got.start_z != want.start_z) report("start_z", want, got);
        if (got.end_x != want.end_x) report("end_x", want, got);
        if (got.end_y != want.end_y) report("end_y", want, got);
        if (got.end_z != want.end_z) report("end_z", want, got);
      end
    end
  end

endmodule

// File: tb/triangle_zero_contour_segment_top_tb.sv
// ----------------------------------------------------------------------------
// triangle_zero_contour_segment_top_tb: isoline segment block testbench
// Sends directed and random triangles under several idle patterns on both
// channels; the checker predicts each segment and counts mismatches.
// ----------------------------------------------------------------------------
module triangle_zero_contour_segment_top_tb;
  import tzc_pkg::*;

  localparam int LATENCY = 21;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 60;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [311:0] in_tdata;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  int           fail_count;
  int           pending;
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_off;
  bit           hold_req;
  bit           hold_ack;
  int           cycles;

  triangle_zero_contour_segment_top dut (.*);

  triangle_zero_contour_segment_checker checker_i (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver: random stalls, or a long hold-off while hold_off counts down.
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      hold_off <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("triangle_zero_contour_segment_top_tb failed");
      $finish;
    end
  end

  function automatic val_t pick_value();
    case ($urandom_range(5))
      0: return val_t'($urandom);
      1: return val_t'($urandom_range(8)) - 4;
      2: return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      default: return val_t'(int'($urandom_range(200000)) - 100000);
    endcase
  endfunction

  function automatic coord_t pick_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 24'sh7fffff : 24'sh800000;
      default: return coord_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t random_triangle();
    in_item_t t;
    t.value_a = pick_value();
    t.value_b = $urandom_range(7) == 0 ? t.value_a : pick_value();
    t.value_c = $urandom_range(7) == 0 ? t.value_b : pick_value();
    t.a_x = pick_coord(); t.a_y = pick_coord(); t.a_z = pick_coord();
    t.b_x = pick_coord(); t.b_y = pick_coord(); t.b_z = pick_coord();
    t.c_x = pick_coord(); t.c_y = pick_coord(); t.c_z = pick_coord();
    return t;
  endfunction

  task automatic send_triangle(in_item_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= t;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic go_quiet();
    in_tvalid <= 1'b0;
    // Waiting on the clock lets the checker log the last accepted request.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic send_values(val_t a, val_t b, val_t c);
    in_item_t t;
    t = random_triangle();
    t.value_a = a;
    t.value_b = b;
    t.value_c = c;
    send_triangle(t);
  endtask

  initial begin
    in_item_t t;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ties, vertices at zero, no crossing, extreme values.
    send_values(0, 0, 0);
    send_values(5, 5, 5);
    send_values(-5, -5, -5);
    send_values(-65536, 65536, 0);
    send_values(0, 65536, 65536);
    send_values(-65536, -65536, 0);
    send_values(0, -1, 1);
    send_values(-1, 0, 0);
    send_values(1, 0, 0);
    send_values(32'sh80000000, 32'sh7fffffff, 0);
    send_values(32'sh7fffffff, 32'sh80000000, 32'sh80000000);
    send_values(3, 3, -3);
    send_values(-3, 3, 3);
    send_values(7, -2, 1);
    t = '0;
    t.value_a = 32'sh80000000;
    t.value_b = 32'sh7fffffff;
    t.value_c = 0;
    t.a_x = 24'sh800000; t.a_y = 24'sh7fffff; t.a_z = 24'sh800000;
    t.b_x = 24'sh7fffff; t.b_y = 24'sh800000; t.b_z = 24'sh7fffff;
    t.c_x = 24'sh7fffff; t.c_y = 24'sh800000; t.c_z = 24'sh800000;
    send_triangle(t);
    t.value_a = -1;
    t.value_b = 2;
    t.value_c = 1;
    send_triangle(t);

    // Sender pauses until the pipeline has drained.
    go_quiet();

    // The receiver holds off long enough for the pipeline to fill and stall.
    hold_req = !hold_req;
    for (int i = 0; i < 80; i++) send_triangle(random_triangle());

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        3: begin send_idle_pct = 27; recv_stall_pct = 27; end
        default: begin send_idle_pct = 0; recv_stall_pct = 0; end
      endcase
      for (int i = 0; i < 240; i++) send_triangle(random_triangle());
    end

    go_quiet();
    recv_stall_pct = 0;
    repeat (LATENCY + 10) @(posedge clk);
    if (fail_count == 0) begin
      $display("triangle_zero_contour_segment_top_tb passed");
    end else begin
      $display("triangle_zero_contour_segment_top_tb failed");
    end
    $finish;
  end

endmodule
